@@ sv/frp_pkg.sv @@
package frp_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 31;
    localparam int CRC_W    = 16;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_XOR  = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 31'h7FFF_FFFF;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_LENGTH   = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_TYPE    = 6'b000010,
        PH_LENGTH  = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_CHECK   = 6'b010000,
        PH_TAIL    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] frame_type;
        t_status           status;
        logic              last;
    } t_result;

    // CRC-16/X.25 update for one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ sv/frp_in_reg.sv @@
module frp_in_reg
    import frp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_start_frame,
    input  logic              i_advance,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_rx_byte,
    output logic              o_start_frame
);

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_rx_byte;
    logic              r_start_frame;
    logic              in_take;

    assign o_in_ready = !r_valid || i_advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (in_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rx_byte     <= i_rx_byte;
            r_start_frame <= i_start_frame;
        end
    end

    assign o_valid       = r_valid;
    assign o_rx_byte     = r_rx_byte;
    assign o_start_frame = r_start_frame;

endmodule

@@ sv/frp_parse.sv @@
module frp_parse
    import frp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_start_frame,
    input  logic              i_out_free,
    output logic              o_advance,
    output logic              o_emit,
    output t_result           o_result
);

    logic [LEN_W-1:0]  r_max_length;
    t_phase            r_phase,   n_phase;
    logic [1:0]        r_idx,     n_idx;
    logic [23:0]       r_len_lo,  n_len_lo;
    logic [LEN_W-1:0]  r_remain,  n_remain;
    logic [CRC_W-1:0]  r_crc,     n_crc;
    logic [CRC_W-1:0]  r_chk,     n_chk;
    logic [BYTE_W-1:0] r_type,    n_type;

    t_phase            cur_phase;
    logic [31:0]       len_full;
    logic [CRC_W-1:0]  crc_upd;
    logic              emit;
    t_result           res;

    assign len_full = {i_rx_byte, r_len_lo};
    assign crc_upd  = crc_byte(r_crc, i_rx_byte);

    always_comb begin
        // a forced start takes the byte as a header
        cur_phase = i_start_frame ? PH_HEADER : r_phase;
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_len_lo  = r_len_lo;
        n_remain  = r_remain;
        n_crc     = r_crc;
        n_chk     = r_chk;
        n_type    = r_type;
        emit      = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = '0;
        res.frame_type   = r_type;
        res.status       = ST_OK;
        res.last         = 1'b0;
        case (cur_phase)
            PH_TYPE: begin
                n_type  = i_rx_byte;
                n_crc   = crc_upd;
                n_idx   = 2'd0;
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_crc = crc_upd;
                case (r_idx)
                    2'd0: n_len_lo[7:0]   = i_rx_byte;
                    2'd1: n_len_lo[15:8]  = i_rx_byte;
                    2'd2: n_len_lo[23:16] = i_rx_byte;
                    default: n_len_lo     = r_len_lo;
                endcase
                if (r_idx != 2'd3) begin
                    n_idx = r_idx + 2'd1;
                end else begin
                    n_idx = 2'd0;
                    if (len_full[31] || (len_full[LEN_W-1:0] > r_max_length)) begin
                        n_phase    = PH_HEADER;
                        emit       = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ST_LENGTH;
                        res.last   = 1'b1;
                    end else begin
                        n_remain = len_full[LEN_W-1:0];
                        n_phase  = (len_full == '0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_crc    = crc_upd;
                n_remain = r_remain - LEN_W'(1);
                if (r_remain == LEN_W'(1)) begin
                    n_idx   = 2'd0;
                    n_phase = PH_CHECK;
                end
                emit             = 1'b1;
                res.payload_byte = i_rx_byte;
            end
            PH_CHECK: begin
                if (r_idx == 2'd0) begin
                    n_chk[7:0] = i_rx_byte;
                    n_idx      = 2'd1;
                end else begin
                    n_chk[15:8] = i_rx_byte;
                    n_idx       = 2'd0;
                    n_phase     = PH_TAIL;
                end
            end
            PH_TAIL: begin
                n_phase    = PH_HEADER;
                emit       = 1'b1;
                res.kind   = KIND_STATUS;
                res.status = ((r_crc ^ CRC_XOR) == r_chk) ? ST_OK : ST_MISMATCH;
                res.last   = 1'b1;
            end
            default: begin
                n_crc   = crc_byte(CRC_INIT, i_rx_byte);
                n_phase = PH_TYPE;
            end
        endcase
    end

    // hold the item while a result cannot be stored
    assign o_advance = i_valid && (i_out_free || !emit);
    assign o_emit    = emit;
    assign o_result  = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_idx    <= 2'd0;
            r_len_lo <= '0;
            r_remain <= '0;
            r_crc    <= CRC_INIT;
            r_chk    <= '0;
            r_type   <= '0;
        end else if (o_advance) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_len_lo <= n_len_lo;
            r_remain <= n_remain;
            r_crc    <= n_crc;
            r_chk    <= n_chk;
            r_type   <= n_type;
        end
    end

endmodule

@@ sv/frp_out_reg.sv @@
module frp_out_reg
    import frp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ sv/frame_parser_crc16_top.sv @@
// Length-prefixed frame receiver with CRC-16/X.25 check.
// Input channel: one received byte per item (i_rx_byte), with i_start_frame
// forcing that byte to be treated as a new frame header. Handshake is
// i_in_valid / o_in_ready.
// Output channel: o_out_valid / i_out_ready. Payload bytes come out one item
// each (o_out_kind = 0); the tail byte, or a bad length field, produces one
// status item (o_out_kind = 1, o_frame_last = 1) with the frame type and the
// check result. Header, type, length and checksum bytes produce no item.
// A byte accepted at the input passes the input register, then the result
// register, before its item shows at o_out_*. Throughput: one byte per
// cycle unless stalled; the CRC byte update and counters sit between them.
// Stall: the output register holds its item while i_out_ready is low; the
// input register still takes one more byte, and bytes that produce no item
// keep flowing. A byte that produces an item waits until the output frees.
// i_cfg_we writes max_length (31 bits) directly; write it only while idle.
// Reset (synchronous, active low): both registers empty, parser waits for a
// header, max_length returns to 0x7FFFFFFF.
module frame_parser_crc16_top
    import frp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_start_frame,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_kind,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [BYTE_W-1:0] o_frame_type,
    output logic [1:0]        o_status,
    output logic              o_frame_last
);

    logic              s1_valid;
    logic [BYTE_W-1:0] s1_byte;
    logic              s1_sof;
    logic              advance;
    logic              emit;
    logic              out_free;
    t_result           res;
    t_result           out_res;

    frp_in_reg u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .i_start_frame (i_start_frame),
        .i_advance     (advance),
        .o_valid       (s1_valid),
        .o_rx_byte     (s1_byte),
        .o_start_frame (s1_sof)
    );

    frp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (s1_valid),
        .i_rx_byte     (s1_byte),
        .i_start_frame (s1_sof),
        .i_out_free    (out_free),
        .o_advance     (advance),
        .o_emit        (emit),
        .o_result      (res)
    );

    frp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (res),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_res)
    );

    assign o_out_kind     = out_res.kind;
    assign o_payload_byte = out_res.payload_byte;
    assign o_frame_type   = out_res.frame_type;
    assign o_status       = out_res.status;
    assign o_frame_last   = out_res.last;

endmodule

@@ sv/frp_checker.sv @@
module frp_checker
    import frp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_out_kind,
    input logic [BYTE_W-1:0] o_payload_byte,
    input logic [BYTE_W-1:0] o_frame_type,
    input logic [1:0]        o_status,
    input logic              o_frame_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_payload_byte) && $stable(o_status)
            && $stable(o_out_kind) && $stable(o_frame_type) && $stable(o_frame_last))
        else $error("output item changed while stalled");

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_kind == KIND_PAYLOAD) |->
            (o_status == ST_OK) && !o_frame_last)
        else $error("payload item carries status fields");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_kind == KIND_STATUS) |->
            o_frame_last && (o_payload_byte == '0) && (o_status != 2'd3))
        else $error("malformed status item");

endmodule

bind frame_parser_crc16_top frp_checker u_frp_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;
    import frp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned SETTLE       = 6;
    localparam int unsigned LONG_HOLD    = 48;
    localparam int unsigned PHASE_ITEMS  = 90;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned MAX_REPORTS  = 40;

    // shadow parser states
    typedef enum logic [2:0] {
        WAIT_HDR,
        GET_TYPE,
        GET_LEN,
        GET_DATA,
        GET_FCS,
        GET_TAIL
    } parse_state_e;

    // how a directed row gets its byte
    typedef enum logic [1:0] {
        PICK_RAW,
        PICK_LO,
        PICK_HI,
        PICK_LO_BAD
    } byte_pick_e;

    typedef struct packed {
        logic [7:0] b;
        logic       sof;
        byte_pick_e pick;
        logic       typed;
        t_result    want;
    } dir_row_t;

    localparam t_result NO_ITEM = '0;

    localparam dir_row_t DIRECTED [27] = '{
        // frame abandoned after the type byte
        '{8'hA5, 1'b1, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h11, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        // forced header, then a negative length
        '{8'hFF, 1'b1, PICK_RAW, 1'b0, NO_ITEM},
        '{8'hFF, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h80, 1'b0, PICK_RAW, 1'b1, '{KIND_STATUS, 8'h00, 8'hFF, ST_LENGTH, 1'b1}},
        // one payload byte, low checksum byte spoiled
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h5A, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h01, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'hFF, 1'b0, PICK_RAW, 1'b1, '{KIND_PAYLOAD, 8'hFF, 8'h5A, ST_OK, 1'b0}},
        '{8'h00, 1'b0, PICK_LO_BAD, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_HI, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b1, '{KIND_STATUS, 8'h00, 8'h5A, ST_MISMATCH, 1'b1}},
        // zero length, good checksum
        '{8'h7E, 1'b1, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_RAW, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_LO, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, PICK_HI, 1'b0, NO_ITEM},
        '{8'hFF, 1'b0, PICK_RAW, 1'b0, NO_ITEM}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [LEN_W-1:0]  i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_rx_byte;
    logic              i_start_frame;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_out_kind;
    logic [BYTE_W-1:0] o_payload_byte;
    logic [BYTE_W-1:0] o_frame_type;
    logic [1:0]        o_status;
    logic              o_frame_last;

    // shadow of the parser
    parse_state_e     sh_phase = WAIT_HDR;
    logic [1:0]       sh_idx   = '0;
    logic [31:0]      sh_len   = '0;
    logic [31:0]      sh_left  = '0;
    logic [15:0]      sh_crc   = 16'hFFFF;
    logic [15:0]      sh_fcs   = '0;
    logic [7:0]       sh_type  = '0;
    logic [LEN_W-1:0] sh_max   = MAX_LENGTH_RST;

    t_result     due_items [$];
    int unsigned errors      = 0;
    int unsigned items_sent  = 0;
    int          budget      = 0;
    bit          in_sync     = 1'b1;
    bit          calm        = 1'b0;
    bit          long_hold_req = 1'b0;

    frame_parser_crc16_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_start_frame  (i_start_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_kind     (o_out_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_type   (o_frame_type),
        .o_status       (o_status),
        .o_frame_last   (o_frame_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // reflected CRC-16, one bit at a time
    function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ 16'h8408;
            end
        end
        return c;
    endfunction

    function automatic bit parse_rx_byte(input logic [7:0] b, input logic sof,
                                         output t_result item);
        bit hit;
        hit  = 1'b0;
        item = NO_ITEM;
        if (sof) begin
            sh_phase = WAIT_HDR;
        end
        case (sh_phase)
            GET_TYPE: begin
                sh_type  = b;
                sh_crc   = x25_update(sh_crc, b);
                sh_idx   = '0;
                sh_len   = '0;
                sh_phase = GET_LEN;
            end
            GET_LEN: begin
                sh_crc = x25_update(sh_crc, b);
                sh_len = sh_len | (32'(b) << (8 * sh_idx));
                if (sh_idx != 2'd3) begin
                    sh_idx = sh_idx + 2'd1;
                end else begin
                    sh_idx = '0;
                    if (sh_len[31] || sh_len > {1'b0, sh_max}) begin
                        sh_phase = WAIT_HDR;
                        item = '{KIND_STATUS, 8'h00, sh_type, ST_LENGTH, 1'b1};
                        hit  = 1'b1;
                    end else begin
                        sh_left  = sh_len;
                        sh_fcs   = '0;
                        sh_phase = (sh_len == 32'd0) ? GET_FCS : GET_DATA;
                    end
                end
            end
            GET_DATA: begin
                sh_crc  = x25_update(sh_crc, b);
                sh_left = sh_left - 32'd1;
                if (sh_left == 32'd0) begin
                    sh_idx   = '0;
                    sh_fcs   = '0;
                    sh_phase = GET_FCS;
                end
                item = '{KIND_PAYLOAD, b, sh_type, ST_OK, 1'b0};
                hit  = 1'b1;
            end
            GET_FCS: begin
                if (sh_idx == 2'd0) begin
                    sh_fcs = {8'h00, b};
                    sh_idx = 2'd1;
                end else begin
                    sh_fcs[15:8] = b;
                    sh_idx   = '0;
                    sh_phase = GET_TAIL;
                end
            end
            GET_TAIL: begin
                sh_phase = WAIT_HDR;
                item = '{KIND_STATUS, 8'h00, sh_type,
                         ((sh_crc ^ 16'hFFFF) == sh_fcs) ? ST_OK : ST_MISMATCH, 1'b1};
                hit  = 1'b1;
            end
            default: begin
                // header byte, also the way out of any stray state
                sh_crc   = x25_update(16'hFFFF, b);
                sh_phase = GET_TYPE;
            end
        endcase
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t mismatch on %0s: got %h, want %h", $time, what, got, want);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic sof,
                             input bit typed = 1'b0, input t_result typed_item = '0);
        t_result     item;
        int unsigned gap;
        logic        rdy;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rx_byte     <= b;
        i_start_frame <= sof;
        // ready is settled by the falling edge and holds through the next rising edge
        do begin
            @(negedge i_clk);
            rdy = o_in_ready;
            @(posedge i_clk);
        end while (rdy !== 1'b1);
        items_sent++;
        if (parse_rx_byte(b, sof, item)) begin
            due_items.push_back(typed ? typed_item : item);
        end
    endtask

    // drop bytes once a truncated frame has used up its budget
    task automatic put_byte(input logic [7:0] b, input logic sof);
        if (budget > 0) begin
            budget--;
            send_byte(b, sof);
        end
    endtask

    task automatic send_frame(input bit long_payload);
        int unsigned pick;
        int unsigned span;
        logic [31:0] flen;
        logic [15:0] spoil;
        logic [15:0] fcs;
        bit          bad_len;
        pick = long_payload ? 0 : $urandom_range(0, 99);
        if (pick >= 90) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            in_sync = 1'b0;
            return;
        end
        budget  = (pick >= 80) ? $urandom_range(1, 12) : 32'h4000_0000;
        bad_len = (pick >= 70 && pick < 80);
        span    = (sh_max < 31'd8) ? int'(sh_max) : 8;
        if (long_payload) begin
            flen = 32'd40;
        end else if (bad_len) begin
            if (sh_max != MAX_LENGTH_RST && $urandom_range(0, 1) == 1) begin
                flen = {1'b0, sh_max} + 32'($urandom_range(1, 8));
            end else begin
                flen = {1'b1, 31'($urandom)};
            end
        end else begin
            flen = 32'($urandom_range(0, span));
        end
        // force a header when the parser may be out of sync, and at random otherwise
        put_byte(8'($urandom), !in_sync || $urandom_range(0, 1) == 1);
        put_byte(8'($urandom), 1'b0);
        for (int k = 0; k < 4; k++) begin
            put_byte(flen[8*k +: 8], 1'b0);
        end
        if (!bad_len) begin
            for (int unsigned n = 0; n < flen; n++) begin
                put_byte(8'($urandom), 1'b0);
            end
            spoil = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0;
            fcs   = sh_crc ^ 16'hFFFF ^ spoil;
            put_byte(fcs[7:0], 1'b0);
            put_byte(fcs[15:8], 1'b0);
            put_byte(8'($urandom), 1'b0);
        end
        in_sync = (pick < 80);
    endtask

    // hold the input side until every expected item is out and the pipe is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (due_items.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [LEN_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sh_max = value;
    endtask

    initial begin : stimulus
        dir_row_t         row;
        logic [15:0]      good_fcs;
        logic [7:0]       b;
        logic [LEN_W-1:0] max_len;
        int unsigned      target;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_rx_byte     = '0;
        i_start_frame = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            row      = DIRECTED[i];
            good_fcs = sh_crc ^ 16'hFFFF;
            case (row.pick)
                PICK_LO:     b = good_fcs[7:0];
                PICK_HI:     b = good_fcs[15:8];
                PICK_LO_BAD: b = ~good_fcs[7:0];
                default:     b = row.b;
            endcase
            send_byte(b, row.sof, row.typed, row.want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                1:       max_len = '0;
                2:       max_len = 31'd1;
                3:       max_len = 31'($urandom_range(2, 9));
                4:       max_len = 31'($urandom);
                default: max_len = MAX_LENGTH_RST;
            endcase
            cfg_write(max_len);
            calm = (p == NUM_PHASES - 1);
            if (p == 0) begin
                // stall the output while a long payload keeps coming
                long_hold_req = 1'b1;
                send_frame(1'b1);
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                send_frame(1'b0);
            end
        end

        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : result_side
        t_result     want;
        int unsigned stall_left;
        logic        s_valid;
        logic        s_kind;
        logic [7:0]  s_byte;
        logic [7:0]  s_type;
        logic [1:0]  s_status;
        logic        s_last;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            // take the item as it stands ahead of the rising edge
            @(negedge i_clk);
            s_valid  = o_out_valid;
            s_kind   = o_out_kind;
            s_byte   = o_payload_byte;
            s_type   = o_frame_type;
            s_status = o_status;
            s_last   = o_frame_last;
            @(posedge i_clk);
            if (i_rst_n && s_valid === 1'b1 && i_out_ready) begin
                if (due_items.size() == 0) begin
                    report_mismatch("unexpected item", s_byte, 8'h00);
                end else begin
                    want = due_items.pop_front();
                    if (s_kind !== want.kind) begin
                        report_mismatch("out_kind", s_kind, want.kind);
                    end
                    if (s_byte !== want.payload_byte) begin
                        report_mismatch("payload_byte", s_byte, want.payload_byte);
                    end
                    if (s_type !== want.frame_type) begin
                        report_mismatch("frame_type", s_type, want.frame_type);
                    end
                    if (s_status !== want.status) begin
                        report_mismatch("status", s_status, want.status);
                    end
                    if (s_last !== want.last) begin
                        report_mismatch("frame_last", s_last, want.last);
                    end
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(negedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/frp_pkg.sv
sv/frp_in_reg.sv
sv/frp_parse.sv
sv/frp_out_reg.sv
sv/frame_parser_crc16_top.sv
sv/frp_checker.sv
tb/tb_top.sv
